// ----- sv/mclb_pkg.sv -----
package mclb_pkg;

  // Field widths fixed by the item format
  localparam int unsigned OPCODE_W = 3;
  localparam int unsigned UNIT_W   = 2;
  localparam int unsigned MS_W     = 16;
  localparam int unsigned STEP_W   = 10;
  localparam int unsigned MASK_W   = 3;

  // Unit count limits; unit indexes compare at a width that holds the largest
  localparam int unsigned NUM_UNITS_DEF = 3;
  localparam int unsigned UNIT_IDX_W    = 5;

  localparam logic [STEP_W-1:0] TICK_STEP_RST = 10'd10;

  typedef enum logic [OPCODE_W-1:0] {
    OP_TICK       = 3'd0,
    OP_SET_FIXED  = 3'd1,
    OP_SET_BLINK  = 3'd2,
    OP_SET_COUNT  = 3'd3,
    OP_CLEAR_UNIT = 3'd4,
    OP_CLEAR_ALL  = 3'd5
  } opcode_t;

  // Per-unit command decoded from one item
  typedef struct packed {
    logic fire;        // the item is processed this cycle
    logic tick;        // advance the blink timer
    logic set;         // clear, then turn on
    logic blink;       // set loads the toggle period
    logic count_mode;  // set loads the toggle count
    logic clear;       // clear the unit
  } unit_cmd_t;

endpackage

// ----- sv/mclb_unit.sv -----
module mclb_unit (
  input  logic                       clk,
  input  logic                       rst,
  input  mclb_pkg::unit_cmd_t        cmd,
  input  logic [mclb_pkg::STEP_W-1:0] tick_step,
  input  logic [mclb_pkg::MS_W-1:0]  delay,
  input  logic [mclb_pkg::MS_W-1:0]  count,
  output logic                       led_next
);
  import mclb_pkg::*;

  logic            blink_on, blink_on_next;
  logic            count_on, count_on_next;
  logic            led_level;
  logic [MS_W-1:0] toggle_period, toggle_period_next;
  logic [MS_W-1:0] elapsed_ms, elapsed_ms_next;
  logic [MS_W-1:0] toggles_left, toggles_left_next;

  logic [MS_W:0]   sum;
  logic [MS_W-1:0] elapsed_sat;
  logic [MS_W-1:0] toggles_dec;

  // Saturating timer advance and wrapping count decrement
  assign sum         = {1'b0, elapsed_ms} + {{(MS_W + 1 - STEP_W){1'b0}}, tick_step};
  assign elapsed_sat = sum[MS_W] ? {MS_W{1'b1}} : sum[MS_W-1:0];
  assign toggles_dec = toggles_left - {{(MS_W-1){1'b0}}, 1'b1};

  // Next state for this unit
  always_comb begin
    blink_on_next      = blink_on;
    count_on_next      = count_on;
    led_next           = led_level;
    toggle_period_next = toggle_period;
    elapsed_ms_next    = elapsed_ms;
    toggles_left_next  = toggles_left;
    if (cmd.fire) begin
      if (cmd.clear) begin
        blink_on_next      = 1'b0;
        count_on_next      = 1'b0;
        led_next           = 1'b0;
        toggle_period_next = '0;
        elapsed_ms_next    = '0;
        toggles_left_next  = '0;
      end else if (cmd.set) begin
        blink_on_next      = cmd.blink;
        count_on_next      = cmd.count_mode;
        led_next           = 1'b1;
        toggle_period_next = cmd.blink ? delay : '0;
        elapsed_ms_next    = '0;
        toggles_left_next  = cmd.count_mode ? count : '0;
      end else if (cmd.tick && blink_on) begin
        if (elapsed_sat >= toggle_period) begin
          elapsed_ms_next = '0;
          led_next        = ~led_level;
          if (count_on) begin
            toggles_left_next = toggles_dec;
            // Stop with the LED off once the last toggle is spent
            if (toggles_dec == '0) begin
              blink_on_next = 1'b0;
              count_on_next = 1'b0;
              led_next      = 1'b0;
            end
          end
        end else begin
          elapsed_ms_next = elapsed_sat;
        end
      end
    end
  end

  // Hold unit state
  always_ff @(posedge clk) begin
    if (rst) begin
      blink_on      <= 1'b0;
      count_on      <= 1'b0;
      led_level     <= 1'b0;
      toggle_period <= '0;
      elapsed_ms    <= '0;
      toggles_left  <= '0;
    end else begin
      blink_on      <= blink_on_next;
      count_on      <= count_on_next;
      led_level     <= led_next;
      toggle_period <= toggle_period_next;
      elapsed_ms    <= elapsed_ms_next;
      toggles_left  <= toggles_left_next;
    end
  end

endmodule

// ----- sv/multi_channel_led_blinker.sv -----
// Channel  | Signals                                            | Direction
// ---------+----------------------------------------------------+----------
// input    | in_valid, in_ready, opcode, unit, blink_delay,      | in
//          | repeat_count                                       |
// result   | out_valid, out_ready, led_mask                     | out
// config   | cfg_valid, cfg_ready, tick_step_ms                 | in
//
// One item is accepted per cycle while in_ready is high; its led_mask is
// loaded from the input register into the result register when that has room.
// Reset (rst, synchronous) turns all LEDs off and loads a 10 ms tick step.
// When out_ready is low the result register holds, the input register takes
// one more item, and in_ready then drops until the result is taken.
module multi_channel_led_blinker #(
  parameter int unsigned NUM_UNITS = mclb_pkg::NUM_UNITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [mclb_pkg::OPCODE_W-1:0]  opcode,
  input  logic [mclb_pkg::UNIT_W-1:0]    unit,
  input  logic [mclb_pkg::MS_W-1:0]      blink_delay,
  input  logic [mclb_pkg::MS_W-1:0]      repeat_count,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [mclb_pkg::MASK_W-1:0]    led_mask,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [mclb_pkg::STEP_W-1:0]    tick_step_ms
);
  import mclb_pkg::*;

  logic [STEP_W-1:0]   tick_step;
  logic                s1_valid;
  logic [OPCODE_W-1:0] s1_opcode;
  logic [UNIT_W-1:0]   s1_unit;
  logic [MS_W-1:0]     s1_delay;
  logic [MS_W-1:0]     s1_count;
  logic                s1_advance;
  logic [NUM_UNITS-1:0] led_next;
  logic [MASK_W-1:0]   mask_next;

  // Take configuration writes at any time
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_step <= TICK_STEP_RST;
    end else if (cfg_valid) begin
      tick_step <= tick_step_ms;
    end
  end

  // Advance the input register into the result register when it has room
  assign s1_advance = s1_valid && (!out_valid || out_ready);
  assign in_ready   = !s1_valid || s1_advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_opcode <= opcode;
      s1_unit   <= unit;
      s1_delay  <= blink_delay;
      s1_count  <= repeat_count;
    end
  end

  // Decode the item for each unit and update them in parallel
  for (genvar i = 0; i < NUM_UNITS; i++) begin : g_unit
    localparam logic [UNIT_IDX_W-1:0] UNIT_IDX = UNIT_IDX_W'(i);
    logic      hit;
    unit_cmd_t cmd;

    assign hit = ({{(UNIT_IDX_W - UNIT_W){1'b0}}, s1_unit} == UNIT_IDX);

    assign cmd.fire       = s1_advance;
    assign cmd.tick       = (s1_opcode == OP_TICK);
    assign cmd.set        = hit && ((s1_opcode == OP_SET_FIXED) ||
                                    (s1_opcode == OP_SET_BLINK) ||
                                    (s1_opcode == OP_SET_COUNT));
    assign cmd.blink      = (s1_opcode == OP_SET_BLINK) || (s1_opcode == OP_SET_COUNT);
    assign cmd.count_mode = (s1_opcode == OP_SET_COUNT);
    assign cmd.clear      = (hit && (s1_opcode == OP_CLEAR_UNIT)) ||
                            (s1_opcode == OP_CLEAR_ALL);

    mclb_unit u_unit (
      .clk       (clk),
      .rst       (rst),
      .cmd       (cmd),
      .tick_step (tick_step),
      .delay     (s1_delay),
      .count     (s1_count),
      .led_next  (led_next[i])
    );
  end

  // Show only the units that fit in the mask
  for (genvar b = 0; b < MASK_W; b++) begin : g_mask
    if (b < NUM_UNITS) begin : g_on
      assign mask_next[b] = led_next[b];
    end else begin : g_off
      assign mask_next[b] = 1'b0;
    end
  end

  // Result register: hold until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance) begin
      led_mask <= mask_next;
    end
  end

endmodule
